@@ sv/ces_pkg.sv @@
`timescale 1ns / 1ps
// ces_pkg: shared types, constants and an offset helper for the contour edge splitter.
// No dependencies.
package ces_pkg;

    localparam int MARKS_DEF = 16;

    // config register indexes
    localparam logic [0:0] CFG_MARK_COUNT = 1'b0;
    localparam logic [0:0] CFG_EPS        = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SPLIT = 1'b1;

    typedef struct packed {
        logic               action;
        logic        [3:0]  mark_index;
        logic signed [31:0] mark_value;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_value;
        logic               start_level;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_value;
        logic               end_level;
    } t_in;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_value;
        logic               vertex_level;
        logic               is_inserted;
        logic               last_vertex;
    } t_out;

    // low endpoint moved by a truncated offset toward the high endpoint
    function automatic logic [31:0] apply_off(input logic [31:0] lo, input logic neg,
                                              input logic [32:0] off);
        logic [31:0] r;
        if (neg) begin
            r = lo - off[31:0];
        end else begin
            r = lo + off[31:0];
        end
        return r;
    endfunction

endpackage

@@ sv/ces_div.sv @@
`timescale 1ns / 1ps
// ces_div: restoring divider, one quotient bit per cycle, 32-bit fraction.
// Depends on nothing; used by contour_edge_splitter.
module ces_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,   // below i_den
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [33:0] r_rem, n_rem, w_sh;
    logic [31:0] r_q, n_q;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_run, n_run, r_done, n_done;

    always_comb begin
        w_sh   = {r_rem[32:0], 1'b0};
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = {1'b0, i_num};
            n_cnt = 6'd0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (w_sh >= {1'b0, i_den}) begin
                n_rem = w_sh - {1'b0, i_den};
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

@@ sv/ces_mul.sv @@
`timescale 1ns / 1ps
// ces_mul: registered 33x32 scaling, offset = floor(mag * p / 2^32).
// Depends on nothing; used by contour_edge_splitter.
module ces_mul (
    input  logic        i_clk,
    input  logic [32:0] i_mag,
    input  logic [31:0] i_p,
    output logic [32:0] o_off    // valid the cycle after the inputs
);
    logic [63:0] r_prod;
    logic [31:0] r_hi_add;

    // top magnitude bit contributes p itself after the shift
    always_ff @(posedge i_clk) begin
        r_prod   <= {32'd0, i_mag[31:0]} * {32'd0, i_p};
        r_hi_add <= i_mag[32] ? i_p : 32'd0;
    end

    assign o_off = {1'b0, r_prod[63:32]} + {1'b0, r_hi_add};
endmodule

@@ sv/contour_edge_splitter.sv @@
`timescale 1ns / 1ps
// contour_edge_splitter: splits a mesh edge at loaded contour marks.
// A load writes a table entry; a split emits the low endpoint, then for each mark inside the
// value span runs the 32-step divider and the multiplier and emits an inserted vertex, then
// the high endpoint; an edge below eps skips the scan. Items are taken only in idle, one load
// per cycle. Results are strobed and cannot be stalled.
// Sync active-low reset clears control and config (mark_count 0, eps 1); table not reset.
module contour_edge_splitter #(
    parameter int MARKS = ces_pkg::MARKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  ces_pkg::t_in  i_item,
    output logic          o_strobe,
    output ces_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    localparam int AW = (MARKS > 1) ? $clog2(MARKS) : 1;
    localparam int CW = $clog2(MARKS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MULX = 3'd4;
    localparam logic [2:0] S_MULY = 3'd5;
    localparam logic [2:0] S_MID  = 3'd6;
    localparam logic [2:0] S_HI   = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_i, n_i, w_n;
    logic [4:0]  r_mark_count;
    logic [15:0] r_eps;

    // ordered endpoints
    logic signed [31:0] r_lx, r_ly, r_lv, r_hx, r_hy, r_hv;
    logic               r_ll, r_hl;
    logic [32:0]        r_diff;
    logic [32:0]        w_diff;
    logic signed [31:0] r_mark, r_vx;

    logic signed [31:0] r_table [MARKS];
    logic signed [31:0] w_m;

    logic          r_strobe, n_strobe;
    ces_pkg::t_out r_out, n_out;

    logic [32:0] w_dx, w_dy, w_magx, w_magy, w_mag, w_num, w_off;
    logic        w_div_start, w_div_done;
    logic [31:0] w_p;
    logic        w_swap;

    // mark count saturates at table depth
    assign w_n = ({27'd0, r_mark_count} > 32'(MARKS)) ? CW'(MARKS) : CW'(r_mark_count);
    assign w_m = r_table[r_i[AW-1:0]];

    // value span of the ordered edge, never negative
    assign w_diff = {r_hv[31], r_hv} - {r_lv[31], r_lv};

    assign w_dx   = {r_hx[31], r_hx} - {r_lx[31], r_lx};
    assign w_dy   = {r_hy[31], r_hy} - {r_ly[31], r_ly};
    assign w_magx = w_dx[32] ? -w_dx : w_dx;
    assign w_magy = w_dy[32] ? -w_dy : w_dy;
    assign w_mag  = (r_state == S_MULY) ? w_magy : w_magx;
    assign w_num  = {w_m[31], w_m} - {r_lv[31], r_lv};
    assign w_swap = i_item.start_value > i_item.end_value;

    ces_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_diff),
        .o_done  (w_div_done),
        .o_q     (w_p)
    );

    // one multiplier, x then y
    ces_mul u_mul (
        .i_clk (i_clk),
        .i_mag (w_mag),
        .i_p   (w_p),
        .o_off (w_off)
    );

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_strobe    = 1'b0;
        n_out       = r_out;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_item.action == ces_pkg::ACT_SPLIT) begin
                    n_state = S_LO;
                end
            end
            S_LO: begin
                n_strobe           = 1'b1;
                n_out.vertex_x     = r_lx;
                n_out.vertex_y     = r_ly;
                n_out.vertex_value = r_lv;
                n_out.vertex_level = r_ll;
                n_out.is_inserted  = 1'b0;
                n_out.last_vertex  = 1'b0;
                n_i                = '0;
                n_state = (w_diff >= {17'd0, r_eps}) ? S_SCAN : S_HI;
            end
            S_SCAN: begin
                if (r_i >= w_n) begin
                    n_state = S_HI;
                end else if (r_lv < w_m && w_m < r_hv) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_MID;
            S_MID: begin
                n_strobe           = 1'b1;
                n_out.vertex_x     = r_vx;
                n_out.vertex_y     = ces_pkg::apply_off(r_ly, w_dy[32], w_off);
                n_out.vertex_value = r_mark;
                n_out.vertex_level = 1'b0;
                n_out.is_inserted  = 1'b1;
                n_out.last_vertex  = 1'b0;
                n_i                = r_i + CW'(1);
                n_state            = S_SCAN;
            end
            S_HI: begin
                n_strobe           = 1'b1;
                n_out.vertex_x     = r_hx;
                n_out.vertex_y     = r_hy;
                n_out.vertex_value = r_hv;
                n_out.vertex_level = r_hl;
                n_out.is_inserted  = 1'b0;
                n_out.last_vertex  = 1'b1;
                n_state            = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_strobe     <= 1'b0;
            r_mark_count <= 5'd0;
            r_eps        <= 16'd1;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                if (i_cfg_index == ces_pkg::CFG_MARK_COUNT) begin
                    r_mark_count <= i_cfg_data[4:0];
                end else begin
                    r_eps <= i_cfg_data[15:0];
                end
            end
        end
        r_out <= n_out;
        // latch ordered endpoints on accept; a load also writes its table entry
        if (r_state == S_IDLE && i_start) begin
            r_lx <= w_swap ? i_item.end_x       : i_item.start_x;
            r_ly <= w_swap ? i_item.end_y       : i_item.start_y;
            r_lv <= w_swap ? i_item.end_value   : i_item.start_value;
            r_ll <= w_swap ? i_item.end_level   : i_item.start_level;
            r_hx <= w_swap ? i_item.start_x     : i_item.end_x;
            r_hy <= w_swap ? i_item.start_y     : i_item.end_y;
            r_hv <= w_swap ? i_item.start_value : i_item.end_value;
            r_hl <= w_swap ? i_item.start_level : i_item.end_level;
            if (i_item.action == ces_pkg::ACT_LOAD && {28'd0, i_item.mark_index} < 32'(MARKS)) begin
                r_table[AW'(i_item.mark_index)] <= i_item.mark_value;
            end
        end
        if (r_state == S_LO) begin
            r_diff <= w_diff;
        end
        if (w_div_start) begin
            r_mark <= w_m;
        end
        if (r_state == S_MULY) begin
            r_vx <= ces_pkg::apply_off(r_lx, w_dx[32], w_off);
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

    // checks
    a_last_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_vertex) |-> !o_result.is_inserted)
        else $error("last vertex marked as inserted");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");
    a_hi_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HI) |=> (o_strobe && o_result.last_vertex && !o_busy))
        else $error("run did not end with last vertex");
endmodule
